>>> sv/pct_pkg.sv
package pct_pkg;

   // Pipeline geometry. The rotation stage count is capped at the table length.
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 32;
   localparam int CORDIC_CELLS  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   localparam int PREP_STAGES   = 4;
   localparam int POST_STAGES   = 2;
   localparam int PCT_LATENCY   = PREP_STAGES + CORDIC_CELLS + POST_STAGES;

   // Field and datapath widths.
   localparam int POS_W  = 24;
   localparam int ANG_W  = 16;
   localparam int HEAD_W = 17;
   localparam int VEC_W  = 32;
   localparam int ZANG_W = 34;
   localparam int IDX_W  = 5;
   localparam int CSR_W  = 24;

   // Angle constants in 1/128 degree.
   localparam logic signed [17:0] HALF_TURN     = 18'sd23040;
   localparam logic signed [17:0] NEG_HALF_TURN = -18'sd23040;
   localparam logic signed [17:0] FULL_TURN     = 18'sd46080;
   localparam logic signed [17:0] QUARTER_TURN  = 18'sd11520;
   localparam logic signed [17:0] NEG_QUARTER   = -18'sd11520;

   // Reciprocals for the exact division by 45 used in the binary angle conversion.
   localparam logic [14:0] RECIP_SMALL = 15'd23302;
   localparam logic [28:0] RECIP_LARGE = 29'd381774871;
   localparam logic [5:0]  DIV_BASE    = 6'd45;
   localparam logic [27:0] CONV_BIAS   = 28'd22;

   // CORDIC gain compensation and rounding.
   localparam logic signed [32:0] CORDIC_GAIN = 33'sh09B74EDA8;
   localparam logic signed [64:0] ROUND_HALF  = 65'sh0000000800000000;

   // Saturation limits.
   localparam logic signed [29:0] POS_MAX_EXT = 30'sd8388607;
   localparam logic signed [29:0] POS_MIN_EXT = -30'sd8388608;
   localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_CENTRE_X = 2'd0,
      CSR_CENTRE_Y = 2'd1,
      CSR_ANGLE    = 2'd2,
      CSR_KIND     = 2'd3
   } csr_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic signed [POS_W-1:0] centre_x;
      logic signed [POS_W-1:0] centre_y;
      logic signed [ANG_W-1:0] angle;
      logic                    kind;
   } pct_cfg_type;

   // One item as it travels along the rotation chain.
   typedef struct packed {
      logic                     kind;
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [ZANG_W-1:0] z;
      logic signed [POS_W-1:0]  tx;
      logic signed [POS_W-1:0]  ty;
      logic signed [HEAD_W-1:0] hd;
   } pct_item_type;

   // Clamp a widened position into the 24 bit range.
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [29:0] v);
      logic signed [POS_W-1:0] r;
      if (v > POS_MAX_EXT) begin
         r = POS_MAX;
      end else if (v < POS_MIN_EXT) begin
         r = POS_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // Arctangent of 2^-i as a binary angle, 2^32 per turn.
   function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2FA;
         5'd15:   r = 32'h0000517D;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A30;
         5'd19:   r = 32'h00000518;
         5'd20:   r = 32'h0000028C;
         5'd21:   r = 32'h00000146;
         5'd22:   r = 32'h000000A3;
         5'd23:   r = 32'h00000051;
         5'd24:   r = 32'h00000029;
         5'd25:   r = 32'h00000014;
         5'd26:   r = 32'h0000000A;
         5'd27:   r = 32'h00000005;
         5'd28:   r = 32'h00000003;
         5'd29:   r = 32'h00000001;
         5'd30:   r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> sv/pct_prep.sv
module pct_prep
   import pct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic                     req_mode,
   input  logic signed [POS_W-1:0]  req_pose_x,
   input  logic signed [POS_W-1:0]  req_pose_y,
   input  logic signed [ANG_W-1:0]  req_pose_heading,
   input  pct_cfg_type              cfg,
   output logic                     out_valid,
   output pct_item_type             out_item
);

   // Fields that ride along while the angle is converted.
   typedef struct packed {
      logic                     kind;
      logic signed [24:0]       dx;
      logic signed [24:0]       dy;
      logic signed [POS_W-1:0]  tx;
      logic signed [POS_W-1:0]  ty;
      logic signed [HEAD_W-1:0] hd;
   } pct_carry_type;

   // Stage one: signed angle, wrap, quadrant fold, heading and translation.
   logic signed [17:0] ang_in, wrap_ang, fold_ang, mag_ang, head_sum, head_wrap;
   logic               flip;
   logic signed [24:0] px_ext, py_ext, cx_ext, cy_ext, dx_raw, dy_raw, offx, offy;
   logic signed [29:0] tsum_x, tsum_y;
   pct_carry_type      carry1_in;
   logic [13:0]        mag1_in;

   always_comb begin
      ang_in = 18'(cfg.angle);
      if (req_mode) begin
         ang_in = -ang_in;
      end

      if (ang_in > HALF_TURN) begin
         wrap_ang = ang_in - FULL_TURN;
      end else if (ang_in <= NEG_HALF_TURN) begin
         wrap_ang = ang_in + FULL_TURN;
      end else begin
         wrap_ang = ang_in;
      end

      flip = 1'b0;
      fold_ang = wrap_ang;
      if (wrap_ang > QUARTER_TURN) begin
         flip = 1'b1;
         fold_ang = wrap_ang - HALF_TURN;
      end else if (wrap_ang < NEG_QUARTER) begin
         flip = 1'b1;
         fold_ang = wrap_ang + HALF_TURN;
      end
      mag_ang = fold_ang[17] ? -fold_ang : fold_ang;
      mag1_in = mag_ang[13:0];

      px_ext = 25'(req_pose_x);
      py_ext = 25'(req_pose_y);
      cx_ext = 25'(cfg.centre_x);
      cy_ext = 25'(cfg.centre_y);
      dx_raw = px_ext - cx_ext;
      dy_raw = py_ext - cy_ext;

      head_sum = 18'(req_pose_heading) + ang_in;
      if (head_sum > HALF_TURN) begin
         head_wrap = head_sum - FULL_TURN;
      end else if (head_sum < NEG_HALF_TURN) begin
         head_wrap = head_sum + FULL_TURN;
      end else begin
         head_wrap = head_sum;
      end

      offx = req_mode ? -cx_ext : cx_ext;
      offy = req_mode ? -cy_ext : cy_ext;
      tsum_x = 30'(px_ext) + 30'(offx);
      tsum_y = 30'(py_ext) + 30'(offy);

      carry1_in.kind = cfg.kind;
      carry1_in.dx   = flip ? -dx_raw : dx_raw;
      carry1_in.dy   = flip ? -dy_raw : dy_raw;
      carry1_in.tx   = sat_pos(tsum_x);
      carry1_in.ty   = sat_pos(tsum_y);
      carry1_in.hd   = cfg.kind ? head_wrap[HEAD_W-1:0] : head_sum[HEAD_W-1:0];
   end

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   pct_carry_type carry1_ff, carry2_ff, carry3_ff;
   logic [13:0]   mag1_ff, mag2_ff;
   logic          sgn1_ff, sgn2_ff, sgn3_ff;
   logic [8:0]    qa2_ff, qa3_ff;
   logic [5:0]    ra3_ff;
   pct_item_type  item4_ff;

   // Stage two: whole multiples of 45 in the folded angle magnitude.
   logic [28:0] prod_small;
   logic [8:0]  qa2_in;
   assign prod_small = 29'(mag1_ff) * 29'(RECIP_SMALL);
   assign qa2_in     = prod_small[28:20];

   // Stage three: remainder after the multiples of 45.
   logic [14:0] qa_times;
   logic [13:0] rem_full;
   logic [5:0]  ra3_in;
   assign qa_times = 15'(qa2_ff) * 15'(DIV_BASE);
   assign rem_full = mag2_ff - qa_times[13:0];
   assign ra3_in   = rem_full[5:0];

   // Stage four: fractional part of the binary angle and the start vector.
   logic [27:0]              xnum;
   logic [56:0]              prod_large;
   logic [30:0]              mag_bin;
   logic signed [ZANG_W-1:0] zmag;
   pct_item_type             item4_in;

   always_comb begin
      xnum = {ra3_ff, 22'd0} + CONV_BIAS;
      prod_large = 57'(xnum) * 57'(RECIP_LARGE);
      mag_bin = {qa3_ff, 22'd0} + 31'(prod_large[55:34]);
      zmag = ZANG_W'(mag_bin);
      item4_in.kind = carry3_ff.kind;
      item4_in.x    = VEC_W'(carry3_ff.dx) <<< 4;
      item4_in.y    = VEC_W'(carry3_ff.dy) <<< 4;
      item4_in.z    = sgn3_ff ? -zmag : zmag;
      item4_in.tx   = carry3_ff.tx;
      item4_in.ty   = carry3_ff.ty;
      item4_in.hd   = carry3_ff.hd;
   end

   // Valid bits of the four stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload of the four stages.
   always_ff @(posedge clock) begin
      carry1_ff <= carry1_in;
      mag1_ff   <= mag1_in;
      sgn1_ff   <= fold_ang[17];
      carry2_ff <= carry1_ff;
      mag2_ff   <= mag1_ff;
      sgn2_ff   <= sgn1_ff;
      qa2_ff    <= qa2_in;
      carry3_ff <= carry2_ff;
      sgn3_ff   <= sgn2_ff;
      qa3_ff    <= qa2_ff;
      ra3_ff    <= ra3_in;
      item4_ff  <= item4_in;
   end

   assign out_valid = v4_ff;
   assign out_item  = item4_ff;

endmodule

>>> sv/pct_cordic_cell.sv
module pct_cordic_cell
   import pct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  logic             in_valid,
   input  pct_item_type     in_item,
   output logic             out_valid,
   output pct_item_type     out_item
);

   logic signed [VEC_W-1:0]  sx, sy;
   logic signed [ZANG_W-1:0] atan_z;
   pct_item_type             item_in;
   logic                     valid_ff;
   pct_item_type             item_ff;

   // One micro-rotation, direction chosen by the sign of the residual angle.
   always_comb begin
      sx = in_item.x >>> cell_index;
      sy = in_item.y >>> cell_index;
      atan_z = ZANG_W'(atan_entry(cell_index));
      item_in = in_item;
      if (!in_item.z[ZANG_W-1]) begin
         item_in.x = in_item.x - sy;
         item_in.y = in_item.y + sx;
         item_in.z = in_item.z - atan_z;
      end else begin
         item_in.x = in_item.x + sy;
         item_in.y = in_item.y - sx;
         item_in.z = in_item.z + atan_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> sv/pct_post.sv
module pct_post
   import pct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  pct_item_type             in_item,
   input  pct_cfg_type              cfg,
   output logic                     rsp_valid,
   output logic signed [POS_W-1:0]  rsp_out_x,
   output logic signed [POS_W-1:0]  rsp_out_y,
   output logic signed [HEAD_W-1:0] rsp_out_heading
);

   // Stage one: gain compensation products.
   logic signed [64:0]       prod_x_in, prod_y_in;
   logic signed [64:0]       prod_x_ff, prod_y_ff;
   logic                     v1_ff;
   logic                     kind1_ff;
   logic signed [POS_W-1:0]  tx1_ff, ty1_ff;
   logic signed [HEAD_W-1:0] hd1_ff;

   assign prod_x_in = 65'(in_item.x) * 65'(CORDIC_GAIN);
   assign prod_y_in = 65'(in_item.y) * 65'(CORDIC_GAIN);

   // Stage two: round to whole units, move back to the centre, clamp, select.
   logic signed [64:0]       rsum_x, rsum_y;
   logic signed [28:0]       rx, ry;
   logic signed [29:0]       abs_x, abs_y;
   logic signed [POS_W-1:0]  out_x_in, out_y_in;
   logic                     rsp_valid_ff;
   logic signed [POS_W-1:0]  out_x_ff, out_y_ff;
   logic signed [HEAD_W-1:0] out_hd_ff;

   always_comb begin
      rsum_x = prod_x_ff + ROUND_HALF;
      rsum_y = prod_y_ff + ROUND_HALF;
      rx = rsum_x[64:36];
      ry = rsum_y[64:36];
      abs_x = 30'(cfg.centre_x) + 30'(rx);
      abs_y = 30'(cfg.centre_y) + 30'(ry);
      out_x_in = kind1_ff ? sat_pos(abs_x) : tx1_ff;
      out_y_in = kind1_ff ? sat_pos(abs_y) : ty1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         rsp_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      kind1_ff  <= in_item.kind;
      tx1_ff    <= in_item.tx;
      ty1_ff    <= in_item.ty;
      hd1_ff    <= in_item.hd;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_hd_ff <= hd1_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_out_heading = out_hd_ff;

endmodule

>>> sv/pose_correction_transform_core.sv
// Pipeline: a start transfer passes 4 angle conversion stages, 16 CORDIC cells, each a
// register stage, and 2 gain and output stages before the rsp_valid strobe.
// Throughput: one pose per cycle; the chain of CORDIC cells is fully pipelined.
// Reset clears the configuration registers and all stage valid bits; busy is high only
// while reset is asserted. Results are never held off by the receiver.
module pose_correction_transform_core
   import pct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic signed [POS_W-1:0]  req_pose_x,
   input  logic signed [POS_W-1:0]  req_pose_y,
   input  logic signed [ANG_W-1:0]  req_pose_heading,
   output logic                     rsp_valid,
   output logic signed [POS_W-1:0]  rsp_out_x,
   output logic signed [POS_W-1:0]  rsp_out_y,
   output logic signed [HEAD_W-1:0] rsp_out_heading,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   // Configuration registers.
   pct_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTRE_X: cfg_ff.centre_x <= csr_wdata;
            CSR_CENTRE_Y: cfg_ff.centre_y <= csr_wdata;
            CSR_ANGLE:    cfg_ff.angle    <= csr_wdata[ANG_W-1:0];
            CSR_KIND:     cfg_ff.kind     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A request transfer happens whenever start is high outside reset.
   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // Chain taps between the conversion front end, the cells and the back end.
   logic         tap_valid [0:CORDIC_CELLS];
   pct_item_type tap_item  [0:CORDIC_CELLS];

   pct_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .req_mode         (req_mode),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_heading (req_pose_heading),
      .cfg              (cfg_ff),
      .out_valid        (tap_valid[0]),
      .out_item         (tap_item[0])
   );

   for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_cell
      pct_cordic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .in_valid   (tap_valid[i]),
         .in_item    (tap_item[i]),
         .out_valid  (tap_valid[i+1]),
         .out_item   (tap_item[i+1])
      );
   end

   pct_post u_post (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (tap_valid[CORDIC_CELLS]),
      .in_item         (tap_item[CORDIC_CELLS]),
      .cfg             (cfg_ff),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_heading (rsp_out_heading)
   );

endmodule

>>> sv/pct_monitor.sv
module pct_monitor
   import pct_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic signed [HEAD_W-1:0] rsp_out_heading,
   input logic                     csr_we,
   input logic [1:0]               csr_index,
   input logic [CSR_W-1:0]         csr_wdata
);

   localparam int CNT_W = $clog2(PCT_LATENCY + 1);

   // Cycles since the last reset, saturating once a full pipeline has passed.
   logic [CNT_W-1:0] since_reset_ff, since_reset_in;
   logic             kind_ff;

   assign since_reset_in = (since_reset_ff == CNT_W'(PCT_LATENCY - 1)) ?
                           since_reset_ff : since_reset_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         since_reset_ff <= '0;
         kind_ff        <= 1'b0;
      end else begin
         since_reset_ff <= since_reset_in;
         if (csr_we && (csr_index == CSR_KIND)) begin
            kind_ff <= csr_wdata[0];
         end
      end
   end

   // Every result traces back to a request transfer a fixed latency earlier.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PCT_LATENCY))
      else $error("result strobe without a matching request transfer");

   // Every request transfer yields a result after the fixed latency.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (since_reset_ff == CNT_W'(PCT_LATENCY - 1)) && $past(start && !busy, PCT_LATENCY)
      |-> rsp_valid)
      else $error("request transfer produced no result");

   // In rotation type the heading leaves wrapped into the half-turn range.
   a_heading_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind_ff |->
      (rsp_out_heading <= 17'sd23040) && (rsp_out_heading >= -17'sd23040))
      else $error("rotation heading outside the wrapped range");

endmodule

bind pose_correction_transform_core pct_monitor u_monitor (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_out_heading (rsp_out_heading),
   .csr_we          (csr_we),
   .csr_index       (csr_index),
   .csr_wdata       (csr_wdata)
);
